FILE: src/vdm_pkg.sv
package vdm_pkg;

  // field and accumulator widths
  localparam int ELEM_W   = 16;
  localparam int ABS_W    = 16;
  localparam int SQD_W    = 32;
  localparam int PROD_W   = 32;
  localparam int SQE_W    = 31;
  localparam int ACC_W    = 48;
  localparam int MAXD_W   = 18;
  localparam int ROOT_W   = 24;
  localparam int DVD_W    = 56;
  localparam int SIM_W    = 40;
  localparam int METRIC_W = 2;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  // metric codes
  localparam logic [METRIC_W-1:0] MET_EUC = 2'd0;
  localparam logic [METRIC_W-1:0] MET_MAN = 2'd1;
  localparam logic [METRIC_W-1:0] MET_CHE = 2'd2;
  localparam logic [METRIC_W-1:0] MET_COS = 2'd3;

  // square root operand sources
  localparam logic [1:0] SQ_SRC_MAIN = 2'd0;
  localparam logic [1:0] SQ_SRC_NA   = 2'd1;
  localparam logic [1:0] SQ_SRC_NB   = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic       take;
    logic       sq_start;
    logic [1:0] sq_src;
    logic       latch_a;
    logic       mul_den;
    logic       div_start;
    logic       load_out;
  } vdm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_pend;
    logic sq_done;
    logic div_done;
    logic den_zero;
    logic out_free;
  } vdm_sts_t;

endpackage

FILE: src/vdm_sqrt.sv
module vdm_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [vdm_pkg::ACC_W-1:0]  operand,
  output logic                       done,
  output logic [vdm_pkg::ROOT_W-1:0] root
);

  localparam int RW    = vdm_pkg::ROOT_W;
  localparam int AW    = vdm_pkg::ACC_W;
  localparam int REM_W = RW + 2;
  localparam int CNT_W = $clog2(RW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RW - 1);

  logic [AW-1:0]    op_r, op_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [RW-1:0]    root_r, root_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [REM_W+1:0] rem_sh, trial, diff;
  logic             fits;

  // one result bit per cycle, two operand bits consumed
  always_comb begin
    rem_sh   = {rem_r, op_r[AW-1 -: 2]};
    trial    = {2'b00, root_r, 2'b01};
    diff     = rem_sh - trial;
    fits     = rem_sh >= trial;
    op_nxt   = op_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      op_nxt   = operand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      op_nxt   = {op_r[AW-3:0], 2'b00};
      rem_nxt  = fits ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_nxt = {root_r[RW-2:0], fits};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

FILE: src/vdm_div.sv
module vdm_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [vdm_pkg::DVD_W-1:0] dividend,
  input  logic [vdm_pkg::ACC_W-1:0] divisor,
  output logic                      done,
  output logic [vdm_pkg::DVD_W-1:0] quotient
);

  localparam int NW    = vdm_pkg::DVD_W;
  localparam int DW    = vdm_pkg::ACC_W;
  localparam int CNT_W = $clog2(NW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NW - 1);

  logic [NW-1:0]    quo_r, quo_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [DW-1:0]    dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DW:0]      rem_sh, diff;
  logic             fits;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh   = {rem_r, quo_r[NW-1]};
    diff     = rem_sh - {1'b0, dvs_r};
    fits     = rem_sh >= {1'b0, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[NW-2:0], fits};
      rem_nxt = fits ? diff[DW-1:0] : rem_sh[DW-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: src/vdm_datapath.sv
module vdm_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  vdm_pkg::vdm_cmd_t               cmd,
  output vdm_pkg::vdm_sts_t               sts,
  input  logic [vdm_pkg::METRIC_W-1:0]    metric,
  input  logic [vdm_pkg::IN_TDATA_W-1:0]  in_data,
  input  logic                            in_last,
  input  logic                            out_tready,
  output logic                            out_tvalid,
  output logic [vdm_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tuser
);

  localparam int EW  = vdm_pkg::ELEM_W;
  localparam int BW  = vdm_pkg::ABS_W;
  localparam int QW  = vdm_pkg::SQD_W;
  localparam int PW  = vdm_pkg::PROD_W;
  localparam int SEW = vdm_pkg::SQE_W;
  localparam int AW  = vdm_pkg::ACC_W;
  localparam int MW  = vdm_pkg::MAXD_W;
  localparam int RW  = vdm_pkg::ROOT_W;
  localparam int NW  = vdm_pkg::DVD_W;
  localparam int SW  = vdm_pkg::SIM_W;
  localparam int TW  = vdm_pkg::METRIC_W;

  localparam logic [SW-1:0] SIM_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] SIM_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [AW-1:0] MAIN_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic [AW-1:0] MAIN_MIN = {1'b1, {(AW-1){1'b0}}};

  // element decode and products
  logic signed [EW-1:0] elem_a, elem_b;
  logic signed [EW:0]   diff_s, diff_neg;
  logic [BW-1:0]        abs_d;
  logic [QW-1:0]        sqd;
  logic signed [PW-1:0] prod_ab, prod_aa, prod_bb;

  always_comb begin
    elem_a   = in_data[EW-1:0];
    elem_b   = in_data[2*EW-1:EW];
    diff_s   = {elem_a[EW-1], elem_a} - {elem_b[EW-1], elem_b};
    diff_neg = -diff_s;
    abs_d    = diff_s[EW] ? diff_neg[BW-1:0] : diff_s[BW-1:0];
    sqd      = QW'(abs_d) * QW'(abs_d);
    prod_ab  = PW'(elem_a) * PW'(elem_b);
    prod_aa  = PW'(elem_a) * PW'(elem_a);
    prod_bb  = PW'(elem_b) * PW'(elem_b);
  end

  // product stage
  logic                 s1_vld_r;
  logic                 s1_last_r;
  logic [TW-1:0]        s1_met_r;
  logic [BW-1:0]        s1_ad_r;
  logic [QW-1:0]        s1_sqd_r;
  logic signed [PW-1:0] s1_ab_r;
  logic [SEW-1:0]       s1_sqa_r, s1_sqb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.take;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      s1_last_r <= in_last;
      s1_met_r  <= metric;
      s1_ad_r   <= abs_d;
      s1_sqd_r  <= sqd;
      s1_ab_r   <= prod_ab;
      s1_sqa_r  <= prod_aa[SEW-1:0];
      s1_sqb_r  <= prod_bb[SEW-1:0];
    end
  end

  // saturating accumulators
  logic signed [AW-1:0] main_r, main_nxt;
  logic [AW-1:0]        na_r, na_nxt, nb_r, nb_nxt;
  logic signed [MW-1:0] max_r, max_nxt;
  logic signed [AW+1:0] term, main_sum;
  logic [AW:0]          na_sum, nb_sum;
  logic signed [MW-1:0] ad_ext;

  always_comb begin
    case (s1_met_r)
      vdm_pkg::MET_EUC: term = {{(AW+2-QW){1'b0}}, s1_sqd_r};
      vdm_pkg::MET_MAN: term = {{(AW+2-BW){1'b0}}, s1_ad_r};
      vdm_pkg::MET_COS: term = (AW+2)'(s1_ab_r);
      default:          term = '0;
    endcase
    main_sum = (AW+2)'(main_r) + term;
    na_sum   = {1'b0, na_r} + (AW+1)'(s1_sqa_r);
    nb_sum   = {1'b0, nb_r} + (AW+1)'(s1_sqb_r);
    ad_ext   = {{(MW-BW){1'b0}}, s1_ad_r};
    main_nxt = main_r;
    na_nxt   = na_r;
    nb_nxt   = nb_r;
    max_nxt  = max_r;
    if (cmd.load_out) begin
      main_nxt = '0;
      na_nxt   = '0;
      nb_nxt   = '0;
      max_nxt  = '1;
    end else if (s1_vld_r) begin
      if (main_sum[AW+1:AW-1] == 3'b000 || main_sum[AW+1:AW-1] == 3'b111) begin
        main_nxt = main_sum[AW-1:0];
      end else begin
        main_nxt = main_sum[AW+1] ? MAIN_MIN : MAIN_MAX;
      end
      na_nxt = na_sum[AW] ? '1 : na_sum[AW-1:0];
      nb_nxt = nb_sum[AW] ? '1 : nb_sum[AW-1:0];
      if (ad_ext > max_r) begin
        max_nxt = ad_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_r <= '0;
      na_r   <= '0;
      nb_r   <= '0;
      max_r  <= '1;
    end else begin
      main_r <= main_nxt;
      na_r   <= na_nxt;
      nb_r   <= nb_nxt;
      max_r  <= max_nxt;
    end
  end

  // shared square root
  logic [AW-1:0] sq_operand;
  logic [RW-1:0] sq_root;
  logic          sq_done;

  always_comb begin
    case (cmd.sq_src)
      vdm_pkg::SQ_SRC_MAIN: sq_operand = main_r[AW-1] ? '0 : main_r;
      vdm_pkg::SQ_SRC_NA:   sq_operand = na_r;
      vdm_pkg::SQ_SRC_NB:   sq_operand = nb_r;
      default:              sq_operand = '0;
    endcase
  end

  vdm_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.sq_start),
    .operand (sq_operand),
    .done    (sq_done),
    .root    (sq_root)
  );

  // norm root product
  logic [RW-1:0] root_a_r;
  logic [AW-1:0] den_r;

  always_ff @(posedge clk) begin
    if (cmd.latch_a) begin
      root_a_r <= sq_root;
    end
    if (cmd.mul_den) begin
      den_r <= AW'(root_a_r) * AW'(sq_root);
    end
  end

  // cosine quotient
  logic [AW-1:0] dot_mag, main_neg;
  logic [NW-1:0] quo;
  logic          div_done;

  assign main_neg = -main_r;
  assign dot_mag  = main_r[AW-1] ? main_neg : main_r;

  vdm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ({dot_mag, {(NW-AW){1'b0}}}),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (quo)
  );

  // result selection
  logic signed [AW:0]   neg_main;
  logic signed [MW:0]   neg_max;
  logic                 quo_big;
  logic [SW-1:0]        quo_clip;
  logic [SW-1:0]        res_sim;
  logic                 res_zero;

  always_comb begin
    neg_main = -{main_r[AW-1], main_r};
    neg_max  = -{max_r[MW-1], max_r};
    quo_big  = (|quo[NW-1:SW]) || (quo[SW-1] && (|quo[SW-2:0]));
    quo_clip = quo_big ? SIM_MIN : quo[SW-1:0];
    res_zero = 1'b0;
    case (metric)
      vdm_pkg::MET_EUC: res_sim = '0 - SW'(sq_root);
      vdm_pkg::MET_MAN: begin
        if (neg_main[AW:SW-1] == '0 || neg_main[AW:SW-1] == '1) begin
          res_sim = neg_main[SW-1:0];
        end else begin
          res_sim = neg_main[AW] ? SIM_MIN : SIM_MAX;
        end
      end
      vdm_pkg::MET_CHE: res_sim = SW'(neg_max);
      vdm_pkg::MET_COS: begin
        if (den_r == '0) begin
          res_sim  = '0;
          res_zero = 1'b1;
        end else if (main_r[AW-1]) begin
          res_sim = quo_clip[SW-1] ? SIM_MAX : quo_clip;
        end else begin
          res_sim = '0 - quo_clip;
        end
      end
      default: res_sim = '0;
    endcase
  end

  // output register
  logic          out_vld_r;
  logic [SW-1:0] out_sim_r;
  logic          out_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_sim_r  <= res_sim;
      out_zero_r <= res_zero;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_sim_r;
  assign out_tuser  = out_zero_r;

  // status
  assign sts.last_pend = s1_vld_r && s1_last_r;
  assign sts.sq_done   = sq_done;
  assign sts.div_done  = div_done;
  assign sts.den_zero  = (den_r == '0);
  assign sts.out_free  = !out_vld_r || out_tready;

endmodule

FILE: src/vdm_ctrl.sv
module vdm_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [vdm_pkg::METRIC_W-1:0] metric,
  input  vdm_pkg::vdm_sts_t            sts,
  output vdm_pkg::vdm_cmd_t            cmd
);

  localparam logic [2:0] ST_ACC    = 3'd0;
  localparam logic [2:0] ST_LAUNCH = 3'd1;
  localparam logic [2:0] ST_SQ_E   = 3'd2;
  localparam logic [2:0] ST_SQ_A   = 3'd3;
  localparam logic [2:0] ST_SQ_B   = 3'd4;
  localparam logic [2:0] ST_ZCHK   = 3'd5;
  localparam logic [2:0] ST_DIV    = 3'd6;
  localparam logic [2:0] ST_RES    = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       ready;

  assign ready     = (state_r == ST_ACC) && !sts.last_pend;
  assign in_tready = ready;

  // request acceptance, sequencing of the final roots, product and divide, and the result load
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.take      = in_tvalid && ready;
    cmd.sq_src    = vdm_pkg::SQ_SRC_MAIN;
    case (state_r)
      ST_ACC: begin
        if (sts.last_pend) begin
          state_nxt = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        case (metric)
          vdm_pkg::MET_EUC: begin
            cmd.sq_start = 1'b1;
            cmd.sq_src   = vdm_pkg::SQ_SRC_MAIN;
            state_nxt    = ST_SQ_E;
          end
          vdm_pkg::MET_COS: begin
            cmd.sq_start = 1'b1;
            cmd.sq_src   = vdm_pkg::SQ_SRC_NA;
            state_nxt    = ST_SQ_A;
          end
          default: state_nxt = ST_RES;
        endcase
      end
      ST_SQ_E: begin
        if (sts.sq_done) begin
          state_nxt = ST_RES;
        end
      end
      ST_SQ_A: begin
        if (sts.sq_done) begin
          cmd.latch_a  = 1'b1;
          cmd.sq_start = 1'b1;
          cmd.sq_src   = vdm_pkg::SQ_SRC_NB;
          state_nxt    = ST_SQ_B;
        end
      end
      ST_SQ_B: begin
        if (sts.sq_done) begin
          cmd.mul_den = 1'b1;
          state_nxt   = ST_ZCHK;
        end
      end
      ST_ZCHK: begin
        if (sts.den_zero) begin
          state_nxt = ST_RES;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_RES;
        end
      end
      ST_RES: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_ACC;
        end
      end
      default: state_nxt = ST_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACC;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: src/vector_distance_metric_unit_top.sv
// vector distance metric unit
// input stream: one element pair per request, in_tdata = elem_a (bits 15:0) and
// elem_b (bits 31:16), both signed Q7.8; in_tlast marks the final pair of a vector.
// output stream: one result per vector, out_tdata = similarity (signed Q.8, 40 bits),
// out_tuser = zero_norm (cosine norm product was zero, similarity then 0).
// cfg_wr_en / cfg_wr_data write the metric: 0 euclidean, 1 manhattan,
// 2 chebyshev, 3 cosine; write it only between vectors.
// throughput: element pairs are taken one per cycle through a product stage and
// a saturating accumulate stage. after the last pair in_tready drops while the
// result is formed: directly for manhattan and chebyshev, by a 24-step root for
// euclidean, and for cosine by two 24-step roots on the shared root unit, a root
// product and a 56-step divide.
// the result then sits in the output register; the next vector is accepted at
// once, even while that result waits. if the receiver still stalls when the next
// result is ready, that result is held and in_tready stays low until the output
// register frees.
// reset (rst_n low, synchronous): metric euclidean, accumulators cleared, the
// maximum set to minus one, no result pending.
module vector_distance_metric_unit_top (
  input  logic        clk,
  input  logic        rst_n,
  // elem_a [15:0], elem_b [31:16]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tlast,
  // similarity [39:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,
  // zero_norm [0]
  output logic        out_tuser,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data
);

  vdm_pkg::vdm_cmd_t cmd;
  vdm_pkg::vdm_sts_t sts;
  logic [vdm_pkg::METRIC_W-1:0] metric_r;

  // metric register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_r <= vdm_pkg::MET_EUC;
    end else if (cfg_wr_en) begin
      metric_r <= cfg_wr_data;
    end
  end

  vdm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .metric    (metric_r),
    .sts       (sts),
    .cmd       (cmd)
  );

  vdm_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .metric     (metric_r),
    .in_data    (in_tdata),
    .in_last    (in_tlast),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // no further request taken right after a last request
  a_stall_after_last : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !in_tready)
    else $error("request accepted right after the last pair");

  // a pending result is never overwritten
  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_tvalid || out_tready))
    else $error("result register overwritten while pending");

  // zero norm result carries zero similarity
  a_zero_norm_value : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("zero norm flag with non-zero similarity");

  // accumulation and finalising never overlap
  a_take_only_idle : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |-> !(cmd.sq_start || cmd.div_start || cmd.load_out))
    else $error("request accepted during finalising");

endmodule
